[rtl/idkh_pkg.sv]
`timescale 1ns / 1ps

package idkh_pkg;

    localparam int HASH_W     = 32;
    localparam int KEY_W      = 32;
    localparam int KEY_BITS   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_STEPS  = HASH_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int MIX_LEFT   = 15;
    localparam int MIX_RIGHT  = 17;

    localparam logic [HASH_W-1:0] GOLDEN_MULT = 32'd2654435761;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_VARIANT = 2'd1;

    localparam logic VARIANT_OLD      = 1'b0;
    localparam logic VARIANT_IMPROVED = 1'b1;

    typedef struct packed {
        logic load_word;
        logic mul_step;
        logic prep;
        logic div_step;
        logic out_load;
    } idkh_cmd_t;

    typedef struct packed {
        logic last_word;
        logic size_zero;
        logic out_busy;
    } idkh_sts_t;

endpackage

[rtl/idkh_ctrl.sv]
`timescale 1ns / 1ps

module idkh_ctrl
    import idkh_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      m_tready,
    input  idkh_sts_t sts,
    output idkh_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_PREP = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_word = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                state_next   = sts.last_word ? ST_PREP : ST_IDLE;
            end
            ST_PREP: begin
                cmd.prep = 1'b1;
                cnt_next = '0;
                state_next = sts.size_zero ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!sts.out_busy || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/idkh_dp.sv]
`timescale 1ns / 1ps

module idkh_dp
    import idkh_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [KEY_W-1:0]     s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [HASH_W-1:0]    m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HASH_W-1:0]    cfg_data,
    input  idkh_cmd_t            cmd,
    output idkh_sts_t            sts
);

    logic [HASH_W-1:0]   size_reg;
    logic                variant_reg;
    logic [HASH_W-1:0]   hash_reg;
    logic [KEY_BITS-1:0] word_reg;
    logic                last_reg;
    logic [HASH_W-1:0]   rem_reg;
    logic [HASH_W-1:0]   dvd_reg;
    logic [HASH_W-1:0]   out_reg;
    logic                out_valid_reg;

    logic [HASH_W-1:0]   word_ext;
    logic [HASH_W-1:0]   mul_a;
    logic [HASH_W-1:0]   prod;
    logic [HASH_W-1:0]   hash_next;
    logic [HASH_W-1:0]   mixed;
    logic [HASH_W:0]     rem_sh;
    logic [HASH_W:0]     diff;
    logic [HASH_W-1:0]   rem_next;

    assign word_ext  = {{(HASH_W-KEY_BITS){1'b0}}, word_reg};
    assign mul_a     = (variant_reg == VARIANT_IMPROVED) ? (hash_reg ^ word_ext) : hash_reg;
    assign prod      = mul_a * GOLDEN_MULT;
    assign hash_next = (variant_reg == VARIANT_IMPROVED) ? prod : (prod ^ word_ext);
    assign mixed     = (hash_reg << MIX_LEFT) ^ (hash_reg >> MIX_RIGHT);

    // one restoring step per cycle
    assign rem_sh   = {rem_reg, dvd_reg[HASH_W-1]};
    assign diff     = rem_sh - {1'b0, size_reg};
    assign rem_next = diff[HASH_W] ? rem_sh[HASH_W-1:0] : diff[HASH_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= '0;
            variant_reg   <= VARIANT_OLD;
            hash_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == REG_TABLE_SIZE) begin
                size_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_HASH_VARIANT) begin
                variant_reg <= cfg_data[0];
            end
            if (cmd.mul_step) begin
                hash_reg <= hash_next;
            end else if (cmd.prep) begin
                hash_reg <= '0;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_word) begin
            word_reg <= s_tdata[KEY_BITS-1:0];
            last_reg <= s_tlast;
        end
        if (cmd.prep) begin
            if (size_reg == '0) begin
                rem_reg <= hash_reg;
            end else begin
                rem_reg <= '0;
            end
            dvd_reg <= (variant_reg == VARIANT_IMPROVED) ? mixed : hash_reg;
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_reg << 1;
        end
        if (cmd.out_load) begin
            out_reg <= rem_reg;
        end
    end

    assign sts.last_word = last_reg;
    assign sts.size_zero = (size_reg == '0);
    assign sts.out_busy  = out_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

[rtl/id_key_multiplicative_hash.sv]
`timescale 1ns / 1ps
// channel   ports                              moves
// s_        s_tvalid s_tready s_tdata s_tlast  key word request, tlast marks last word
// m_        m_tvalid m_tready m_tdata          hash value of a complete key
// cfg_      cfg_valid cfg_ready cfg_index      register write (0 table size, 1 variant)
//           cfg_data
// a word that is not last is accepted, then multiplied into the running hash
// a last word passes through accept, multiply, reduce setup, 32 steps of the
// bit-serial restoring divider, output load; with table size zero the 32 steps drop out
// the output register lets the next key start while a result waits on m_tready
// the output load stalls while the previous hash still waits on m_tready
// reset is synchronous on aresetn low and clears the running hash and both registers

module id_key_multiplicative_hash
    import idkh_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [KEY_W-1:0]     s_tdata,   // key_word
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [HASH_W-1:0]    m_tdata,   // hash_value
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HASH_W-1:0]    cfg_data
);

    idkh_cmd_t cmd;
    idkh_sts_t sts;

    assign cfg_ready = 1'b1;

    idkh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    idkh_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import idkh_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 50;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [KEY_W-1:0]     s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [HASH_W-1:0]    m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [HASH_W-1:0]    cfg_data;

    logic [HASH_W-1:0] size_model = '0;
    logic              variant_model = VARIANT_OLD;
    logic [HASH_W-1:0] run_hash = '0;
    logic [HASH_W-1:0] hash_q[$];
    int                errors = 0;
    int                cycle_cnt = 0;
    int                words_sent = 0;
    bit                no_idle = 1'b0;

    id_key_multiplicative_hash uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 32);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (hash_q.size() == 0) begin
                $display("%0t unexpected hash_value: expected none actual %h",
                         $time, m_tdata);
                errors++;
            end else begin
                if (m_tdata !== hash_q[0]) begin
                    $display("%0t hash_value mismatch: expected %h actual %h",
                             $time, hash_q[0], m_tdata);
                    errors++;
                end
                void'(hash_q.pop_front());
            end
        end
    end

    function automatic bit fold_word(input logic [KEY_W-1:0] w, input logic l,
                                     output logic [HASH_W-1:0] r);
        logic [HASH_W-1:0] k;
        logic [HASH_W-1:0] h;
        logic [HASH_W-1:0] m;
        k = {16'h0000, w[KEY_BITS-1:0]};
        if (variant_model == VARIANT_IMPROVED)
            h = (run_hash ^ k) * GOLDEN_MULT;
        else
            h = (run_hash * GOLDEN_MULT) ^ k;
        r = '0;
        if (!l) begin
            run_hash = h;
            return 1'b0;
        end
        if (size_model == 0) begin
            r = h;
        end else if (variant_model == VARIANT_IMPROVED) begin
            m = (h << MIX_LEFT) ^ (h >> MIX_RIGHT);
            r = m % size_model;
        end else begin
            r = h % size_model;
        end
        run_hash = '0;
        return 1'b1;
    endfunction

    task automatic send_word(input logic [KEY_W-1:0] w, input logic l);
        logic [HASH_W-1:0] r;
        while (!no_idle && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (fold_word(w, l, r)) hash_q.push_back(r);
        words_sent++;
    endtask

    // stop sending, wait for every pending hash, then let the block finish a key word
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (hash_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HASH_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_TABLE_SIZE:   size_model = val;
            REG_HASH_VARIANT: variant_model = val[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_mode(input logic [HASH_W-1:0] n, input logic v);
        logic [HASH_W-1:0] vword;
        vword = $urandom();
        vword[0] = v;
        write_reg(REG_TABLE_SIZE, n);
        write_reg(REG_HASH_VARIANT, vword);
    endtask

    task automatic test_reset_defaults();
        send_word(32'h0000_ABCD, 1'b1);
        send_word(32'h1234_5678, 1'b0);
        send_word(32'h9ABC_DEF0, 1'b1);
        settle_block();
    endtask

    task automatic test_extremes();
        set_mode(32'h0000_0000, VARIANT_OLD);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_0000, 1'b1);
        settle_block();
        set_mode(32'h0000_0000, VARIANT_IMPROVED);
        send_word(32'hFFFF_0000, 1'b0);
        send_word(32'h0000_FFFF, 1'b1);
        settle_block();
        set_mode(32'hFFFF_FFFF, VARIANT_IMPROVED);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_0001, 1'b1);
        settle_block();
        set_mode(32'h0000_0001, VARIANT_OLD);
        send_word(32'h0000_1234, 1'b1);
        settle_block();
        set_mode(32'h8000_0000, VARIANT_OLD);
        send_word(32'hFFFF_FFFF, 1'b1);
        settle_block();
        set_mode(32'h0000_0007, VARIANT_IMPROVED);
        send_word(32'hA5A5_5A5A, 1'b0);
        send_word(32'h5A5A_A5A5, 1'b1);
        settle_block();
    endtask

    // variant flips between the words of one key
    task automatic test_variant_mid_key();
        set_mode(32'h0000_03E8, VARIANT_OLD);
        send_word(32'h0000_BEEF, 1'b0);
        settle_block();
        write_reg(REG_HASH_VARIANT, {31'h0, VARIANT_IMPROVED});
        send_word(32'h0000_CAFE, 1'b0);
        settle_block();
        write_reg(REG_HASH_VARIANT, {31'h0, VARIANT_OLD});
        send_word(32'h0000_F00D, 1'b1);
        settle_block();
    endtask

    task automatic test_bad_index();
        set_mode(32'h0000_0065, VARIANT_IMPROVED);
        write_reg(2'd2, 32'hFFFF_FFFF);
        write_reg(2'd3, 32'h0000_0000);
        send_word(32'h0BAD_0BAD, 1'b1);
        settle_block();
    endtask

    task automatic test_random_keys(input int target);
        int phase;
        int nwords;
        int sel;
        logic [HASH_W-1:0] n;
        phase = 0;
        while (words_sent < target) begin
            sel = $urandom_range(9);
            case (sel)
                0, 1:    n = '0;
                2:       n = 32'd1;
                3, 4:    n = $urandom_range(100, 2);
                5:       n = 32'hFFFF_FFFF;
                6:       n = 32'h1 << $urandom_range(31);
                default: n = $urandom();
            endcase
            set_mode(n, 1'($urandom_range(1)));
            no_idle = (phase == 3);
            repeat ($urandom_range(12, 4)) begin
                sel = $urandom_range(99);
                if (sel < 70) nwords = $urandom_range(3, 1);
                else if (sel < 95) nwords = $urandom_range(8, 4);
                else nwords = $urandom_range(20, 9);
                for (int i = 0; i < nwords; i++)
                    send_word($urandom(), i == nwords - 1);
                if ($urandom_range(9) == 0) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (hash_q.size() != 0) @(posedge aclk);
                end
            end
            settle_block();
            phase++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_extremes();
        test_variant_mid_key();
        test_bad_index();
        test_random_keys(words_sent + 550);

        settle_block();
        if (errors == 0 && hash_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[id_key_multiplicative_hash.f]
rtl/idkh_pkg.sv
rtl/idkh_ctrl.sv
rtl/idkh_dp.sv
rtl/id_key_multiplicative_hash.sv
bench/tb.sv
